>>> rtl/sync_length_deframer_top_assert.svh
// Assertion helpers shared by the deframer modules.
// Both expect i_clk and i_rst_n in the enclosing module.
`ifndef SYNC_LENGTH_DEFRAMER_TOP_ASSERT_SVH
`define SYNC_LENGTH_DEFRAMER_TOP_ASSERT_SVH

// Consequent checked on the same edge.
`define SLDE_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("deframer check failed");

// Consequent checked on the following edge.
`define SLDE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("deframer check failed");

`endif

>>> rtl/slde_pkg.sv
package slde_pkg;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 16;

    localparam logic [BYTE_W-1:0] SYNC_B0 = 8'hFF;
    localparam logic [BYTE_W-1:0] SYNC_B1 = 8'h56;  // 'V'
    localparam logic [BYTE_W-1:0] SYNC_B2 = 8'h42;  // 'B'

    localparam logic [LEN_W-1:0] MAX_LEN_RESET = 16'd1024;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
        logic [LEN_W-1:0]  index;
        logic              last;
    } t_result;

endpackage

>>> rtl/slde_parser.sv
`include "sync_length_deframer_top_assert.svh"

module slde_parser (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [slde_pkg::LEN_W-1:0]  i_cfg_wdata,
    input  logic                        i_accept,
    input  logic [slde_pkg::BYTE_W-1:0] i_in_byte,
    output slde_pkg::t_result           o_result
);

    typedef enum logic [2:0] {
        PH_SYNC0  = 3'd0,
        PH_SYNC1  = 3'd1,
        PH_SYNC2  = 3'd2,
        PH_LEN_LO = 3'd3,
        PH_LEN_HI = 3'd4,
        PH_DATA   = 3'd5
    } t_phase;

    t_phase                      r_phase, n_phase;
    logic [slde_pkg::LEN_W-1:0]  r_len, n_len;
    logic [slde_pkg::LEN_W-1:0]  r_pos, n_pos;
    logic [slde_pkg::LEN_W-1:0]  r_max_len;

    t_phase                      restart;
    logic [slde_pkg::LEN_W-1:0]  hdr_len;
    logic [slde_pkg::LEN_W:0]    pos_inc;
    logic                        last;

    assign restart = (i_in_byte == slde_pkg::SYNC_B0) ? PH_SYNC1 : PH_SYNC0;
    assign hdr_len = {i_in_byte, r_len[slde_pkg::BYTE_W-1:0]};
    assign pos_inc = {1'b0, r_pos} + {{slde_pkg::LEN_W{1'b0}}, 1'b1};
    assign last    = (pos_inc >= {1'b0, r_len});

    always_comb begin
        n_phase = r_phase;
        n_len   = r_len;
        n_pos   = r_pos;
        case (r_phase)
            PH_SYNC1: begin
                n_phase = (i_in_byte == slde_pkg::SYNC_B1) ? PH_SYNC2 : restart;
            end
            PH_SYNC2: begin
                n_phase = (i_in_byte == slde_pkg::SYNC_B2) ? PH_LEN_LO : restart;
            end
            PH_LEN_LO: begin
                n_len   = {{(slde_pkg::LEN_W-slde_pkg::BYTE_W){1'b0}}, i_in_byte};
                n_phase = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                n_len = hdr_len;
                // zero or oversized length: drop the frame silently
                if (hdr_len == '0 || hdr_len > r_max_len) begin
                    n_phase = PH_SYNC0;
                end else begin
                    n_pos   = '0;
                    n_phase = PH_DATA;
                end
            end
            PH_DATA: begin
                n_pos = pos_inc[slde_pkg::LEN_W-1:0];
                if (last) begin
                    n_phase = PH_SYNC0;
                end
            end
            default: begin
                n_phase = restart;
            end
        endcase
    end

    always_comb begin
        o_result.valid = (r_phase == PH_DATA);
        o_result.data  = i_in_byte;
        o_result.index = r_pos;
        o_result.last  = last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_SYNC0;
            r_len     <= '0;
            r_pos     <= '0;
            r_max_len <= slde_pkg::MAX_LEN_RESET;
        end else begin
            if (i_accept) begin
                r_phase <= n_phase;
                r_len   <= n_len;
                r_pos   <= n_pos;
            end
            if (i_cfg_we) begin
                r_max_len <= i_cfg_wdata;
            end
        end
    end

    `SLDE_ASSERT_NOW(a_pos_in_frame, r_phase == PH_DATA, r_pos < r_len)
    `SLDE_ASSERT_NEXT(a_last_ends_frame, i_accept && o_result.valid && o_result.last,
                      r_phase == PH_SYNC0)
    `SLDE_ASSERT_NEXT(a_frame_starts_at_zero,
                      i_accept && r_phase == PH_LEN_HI && hdr_len != '0 && hdr_len <= r_max_len,
                      r_phase == PH_DATA && r_pos == '0)

endmodule

>>> rtl/slde_out_reg.sv
`include "sync_length_deframer_top_assert.svh"

module slde_out_reg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_load,
    input  slde_pkg::t_result           i_result,
    input  logic                        i_out_ready,
    output logic                        o_can_load,
    output logic                        o_out_valid,
    output logic [slde_pkg::BYTE_W-1:0] o_payload_byte,
    output logic [slde_pkg::LEN_W-1:0]  o_byte_index,
    output logic                        o_frame_last
);

    logic                        r_valid;
    logic [slde_pkg::BYTE_W-1:0] r_data;
    logic [slde_pkg::LEN_W-1:0]  r_index;
    logic                        r_last;

    // register is free when empty or being drained this cycle
    assign o_can_load = !r_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_can_load) begin
            r_data  <= i_result.data;
            r_index <= i_result.index;
            r_last  <= i_result.last;
        end
    end

    assign o_out_valid    = r_valid;
    assign o_payload_byte = r_data;
    assign o_byte_index   = r_index;
    assign o_frame_last   = r_last;

    `SLDE_ASSERT_NOW(a_no_load_when_stalled, i_load, o_can_load)
    `SLDE_ASSERT_NEXT(a_hold_while_stalled, r_valid && !i_out_ready,
                      r_valid && $stable(r_data) && $stable(r_index) && $stable(r_last))
    `SLDE_ASSERT_NEXT(a_drain_empties, r_valid && i_out_ready && !i_load, !r_valid)

endmodule

>>> rtl/sync_length_deframer_top.sv
// Byte-stream deframer: hunts for the sync word FF 'V' 'B', reads a 16-bit
// payload length (low byte first) and delivers each payload byte with its
// index, flagging the final one. Lengths of zero or above max_payload_len
// (i_cfg_wdata, reset 1024) are dropped without output; a stray FF during
// the hunt restarts it at the second sync byte. A byte is accepted each
// clock whenever the single output register is empty or being read in
// that cycle, so the output side's ready sets the throughput. Header
// bytes produce no output item.
module sync_length_deframer_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [slde_pkg::LEN_W-1:0]  i_cfg_wdata,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [slde_pkg::BYTE_W-1:0] i_in_byte,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [slde_pkg::BYTE_W-1:0] o_payload_byte,
    output logic [slde_pkg::LEN_W-1:0]  o_byte_index,
    output logic                        o_frame_last
);

    logic              in_fire;
    logic              can_load;
    slde_pkg::t_result result;

    assign o_in_ready = can_load;
    assign in_fire    = i_in_valid && can_load;

    slde_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (in_fire),
        .i_in_byte   (i_in_byte),
        .o_result    (result)
    );

    slde_out_reg u_out_reg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (in_fire && result.valid),
        .i_result       (result),
        .i_out_ready    (i_out_ready),
        .o_can_load     (can_load),
        .o_out_valid    (o_out_valid),
        .o_payload_byte (o_payload_byte),
        .o_byte_index   (o_byte_index),
        .o_frame_last   (o_frame_last)
    );

endmodule
